// ===== rtl/core/atdps_pkg.sv =====
// Shared types, constants and angle helpers for the crank-angle delay scheduler.
// No dependencies; the front end, back end, result queue and top import this package.
`timescale 1ns / 1ps
`default_nettype none

package atdps_pkg;

  // Field widths
  localparam int TOOTH_W    = 8;
  localparam int UPD_W      = 20;
  localparam int PW_W       = 20;
  localparam int ADV_W      = 12;
  localparam int ANG_W      = 16;
  localparam int DELAY_W    = 21;
  localparam int TEETH_W    = 8;
  localparam int WHEEL_W    = 9;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEETH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EOI   = 1'b1;

  localparam logic [TEETH_W-1:0] TEETH_RESET = 8'd58;
  localparam logic [ANG_W-1:0]   EOI_RESET   = 16'd0;

  // One turn and half a turn in 0.01 degree
  localparam int unsigned TURN_CD      = 36000;
  localparam int unsigned HALF_TURN_CD = 18000;

  // Numerators of the two divisions, pulse side is the wider one
  localparam int NUM_W    = 35;
  localparam int PW_SCALE = 25600;

  // floor(y/100) = (y * DIV100_MUL) >> DIV100_SHIFT, exact for y < 2**30
  localparam int DIV100_SHIFT = 35;
  localparam logic [28:0] DIV100_MUL = 29'd343597384;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF   = 64;

  typedef struct packed {
    logic [TOOTH_W-1:0] tooth_position;
    logic [UPD_W-1:0]   us_per_degree;
    logic [PW_W-1:0]    pulse_width;
    logic [ADV_W-1:0]   spark_advance;
  } req_t;

  typedef struct packed {
    logic               valid_res;
    logic [DELAY_W-1:0] inject_delay_first;
    logic [DELAY_W-1:0] inject_delay_second;
    logic [DELAY_W-1:0] spark_delay_first;
    logic [DELAY_W-1:0] spark_delay_second;
    logic [PW_W-1:0]    pulse_width_out;
  } res_t;

  // Classified request as handed from the front end to the back end
  typedef struct packed {
    logic               ok;
    logic [TOOTH_W-1:0] tooth;
    logic [WHEEL_W-1:0] wheel;
    logic [UPD_W-1:0]   upd;
    logic [PW_W-1:0]    pw;
    logic [ANG_W-1:0]   eoi0;
    logic [ANG_W-1:0]   eoi180;
    logic [ANG_W-1:0]   sp0;
    logic [ANG_W-1:0]   sp180;
  } job_t;

  // Sum of two angles already inside one turn, wrapped
  function automatic logic [ANG_W-1:0] wrap_add(input logic [ANG_W-1:0] a,
                                                input logic [ANG_W-1:0] b);
    logic [ANG_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (ANG_W+1)'(TURN_CD)) begin
      return ANG_W'(s - (ANG_W+1)'(TURN_CD));
    end
    return s[ANG_W-1:0];
  endfunction

  // Forward angular distance from cur to target, both inside one turn
  function automatic logic [ANG_W-1:0] fwd_dist(input logic [ANG_W-1:0] target,
                                                input logic [ANG_W-1:0] cur);
    logic [ANG_W:0] s;
    s = {1'b0, target} + (ANG_W+1)'(TURN_CD) - {1'b0, cur};
    if (target >= cur) begin
      return target - cur;
    end
    return s[ANG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/atdps_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module atdps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/atdps_front.sv =====
// Front end: configuration registers, request classification and the short job queue.
// Depends on atdps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atdps_front #(
  parameter int unsigned DEPTH = atdps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  atdps_pkg::req_t                    req,
  input  logic                               cfg_we,
  input  logic [atdps_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [atdps_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                               job_valid,
  output atdps_pkg::job_t                    job,
  input  logic                               job_pop
);
  import atdps_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [TEETH_W-1:0] teeth;
  logic [ANG_W-1:0]   eoi;

  job_t            slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   cnt;
  logic            push_acc;
  logic            pop_acc;
  job_t            cls;
  logic [ANG_W:0]  adv_cd;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      teeth <= TEETH_RESET;
      eoi   <= EOI_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TEETH: teeth <= cfg_data[TEETH_W-1:0];
        REG_EOI:   eoi   <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Classify: validity, wheel divisor and the fixed target angles
  always_comb begin
    adv_cd     = (ANG_W+1)'(req.spark_advance) * (ANG_W+1)'(10);
    cls.ok     = (teeth != '0) && (req.us_per_degree != '0);
    cls.tooth  = req.tooth_position;
    cls.wheel  = {1'b0, teeth} + WHEEL_W'(2);
    cls.upd    = req.us_per_degree;
    cls.pw     = req.pulse_width;
    cls.eoi0   = (eoi >= ANG_W'(TURN_CD)) ? (eoi - ANG_W'(TURN_CD)) : eoi;
    cls.eoi180 = wrap_add(cls.eoi0, ANG_W'(HALF_TURN_CD));
    // spark for the first pair: advance before a full turn
    if (adv_cd <= (ANG_W+1)'(TURN_CD)) begin
      cls.sp0 = ANG_W'((ANG_W+1)'(TURN_CD) - adv_cd);
    end else begin
      cls.sp0 = ANG_W'((ANG_W+1)'(2 * TURN_CD) - adv_cd);
    end
    if (adv_cd == '0) begin
      cls.sp0 = '0;
    end
    // spark for the second pair: advance before half a turn
    if (adv_cd <= (ANG_W+1)'(HALF_TURN_CD)) begin
      cls.sp180 = ANG_W'((ANG_W+1)'(HALF_TURN_CD) - adv_cd);
    end else begin
      cls.sp180 = ANG_W'((ANG_W+1)'(TURN_CD + HALF_TURN_CD) - adv_cd);
    end
  end

  // Job queue
  assign full      = (cnt == CW'(DEPTH));
  assign push_acc  = push && !full;
  assign job_valid = (cnt != '0);
  assign pop_acc   = job_pop && job_valid;
  assign job       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_acc) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push_acc) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (pop_acc) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      cnt <= cnt + CW'(push_acc) - CW'(pop_acc);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/atdps_back.sv =====
// Back end: pipelined dividers with modulo-turn reduction, distance and delay stages.
// Depends on atdps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atdps_back #(
  parameter int unsigned OUT_DEPTH = atdps_pkg::OUT_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             job_valid,
  input  atdps_pkg::job_t                  job,
  output logic                             job_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_level,
  output logic                             res_wr,
  output atdps_pkg::res_t                  res_data
);
  import atdps_pkg::*;

  localparam int LVL_W = $clog2(OUT_DEPTH + 1);
  localparam int NSTG  = NUM_W;
  localparam int PROD_W = ANG_W + UPD_W;
  localparam int SCL_W  = 57;

  typedef struct packed {
    logic [NUM_W-1:0]   n1;
    logic [NUM_W-1:0]   n2;
    logic [WHEEL_W-1:0] r1;
    logic [UPD_W-1:0]   r2;
    logic [ANG_W-1:0]   m1;
    logic [ANG_W-1:0]   m2;
    job_t               job;
  } div_st_t;

  // One quotient bit of each division; the quotient is folded modulo a turn
  function automatic div_st_t div_step(input div_st_t s);
    div_st_t        o;
    logic [WHEEL_W:0] t1;
    logic [UPD_W:0] t2;
    logic           q1;
    logic           q2;
    logic [ANG_W:0] a1;
    logic [ANG_W:0] a2;
    o  = s;
    t1 = {s.r1, s.n1[NUM_W-1]};
    t2 = {s.r2, s.n2[NUM_W-1]};
    q1 = (t1 >= {1'b0, s.job.wheel});
    q2 = (t2 >= {1'b0, s.job.upd});
    o.r1 = q1 ? WHEEL_W'(t1 - {1'b0, s.job.wheel}) : t1[WHEEL_W-1:0];
    o.r2 = q2 ? UPD_W'(t2 - {1'b0, s.job.upd}) : t2[UPD_W-1:0];
    o.n1 = {s.n1[NUM_W-2:0], 1'b0};
    o.n2 = {s.n2[NUM_W-2:0], 1'b0};
    a1 = {s.m1, q1};
    a2 = {s.m2, q2};
    o.m1 = (a1 >= (ANG_W+1)'(TURN_CD)) ? ANG_W'(a1 - (ANG_W+1)'(TURN_CD)) : a1[ANG_W-1:0];
    o.m2 = (a2 >= (ANG_W+1)'(TURN_CD)) ? ANG_W'(a2 - (ANG_W+1)'(TURN_CD)) : a2[ANG_W-1:0];
    return o;
  endfunction

  div_st_t           st [NSTG+1];
  logic [NSTG:0]     st_vld;
  logic [3:0]        s_vld;
  logic [LVL_W-1:0]  inflight;
  logic              credit;

  logic [ANG_W-1:0]  s1_tgt [4];
  logic [ANG_W-1:0]  s1_cur;
  logic [UPD_W-1:0]  s1_upd;
  logic [PW_W-1:0]   s1_pw;
  logic              s1_ok;
  logic [ANG_W-1:0]  s2_dist [4];
  logic [UPD_W-1:0]  s2_upd;
  logic [PW_W-1:0]   s2_pw;
  logic              s2_ok;
  logic [PROD_W-1:0] s3_prod [4];
  logic [PW_W-1:0]   s3_pw;
  logic              s3_ok;
  logic [SCL_W-1:0]  s4_scl [4];
  logic [PW_W-1:0]   s4_pw;
  logic              s4_ok;
  logic [DELAY_W-1:0] delay [4];

  // Issue only while the output queue has room for everything in flight
  assign credit  = ({1'b0, inflight} + {1'b0, out_level}) < (LVL_W+1)'(OUT_DEPTH);
  assign job_pop = job_valid && credit;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld   <= '0;
      s_vld    <= '0;
      inflight <= '0;
    end else begin
      st_vld   <= {st_vld[NSTG-1:0], job_pop};
      s_vld    <= {s_vld[2:0], st_vld[NSTG]};
      inflight <= inflight + LVL_W'(job_pop) - LVL_W'(res_wr);
    end
  end

  // Issue stage: numerators of both divisions
  always_ff @(posedge clk) begin
    st[0].n1  <= NUM_W'(24'(job.tooth) * 24'(TURN_CD));
    st[0].n2  <= NUM_W'(job.pw) * NUM_W'(PW_SCALE);
    st[0].r1  <= '0;
    st[0].r2  <= '0;
    st[0].m1  <= '0;
    st[0].m2  <= '0;
    st[0].job <= job;
  end

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < NSTG; k++) begin : g_div
    always_ff @(posedge clk) begin
      st[k+1] <= div_step(st[k]);
    end
  end

  // Start of injection angles; carry the spark angles along
  always_ff @(posedge clk) begin
    s1_tgt[0] <= wrap_add(st[NSTG].job.eoi0, st[NSTG].m2);
    s1_tgt[1] <= wrap_add(st[NSTG].job.eoi180, st[NSTG].m2);
    s1_tgt[2] <= st[NSTG].job.sp0;
    s1_tgt[3] <= st[NSTG].job.sp180;
    s1_cur    <= st[NSTG].m1;
    s1_upd    <= st[NSTG].job.upd;
    s1_pw     <= st[NSTG].job.pw;
    s1_ok     <= st[NSTG].job.ok;
  end

  // Distances, products and the divide by 25600 (shift, then reciprocal of 100)
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s2_dist[i] <= fwd_dist(s1_tgt[i], s1_cur);
      s3_prod[i] <= PROD_W'(s2_dist[i]) * PROD_W'(s2_upd);
      s4_scl[i]  <= SCL_W'(s3_prod[i][PROD_W-1:8]) * SCL_W'(DIV100_MUL);
    end
    s2_upd <= s1_upd;
    s2_pw  <= s1_pw;
    s2_ok  <= s1_ok;
    s3_pw  <= s2_pw;
    s3_ok  <= s2_ok;
    s4_pw  <= s3_pw;
    s4_ok  <= s3_ok;
  end

  // Saturate and mask invalid requests
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (s4_scl[i][SCL_W-1:DIV100_SHIFT+DELAY_W] != '0) begin
        delay[i] = '1;
      end else begin
        delay[i] = s4_scl[i][DIV100_SHIFT+DELAY_W-1:DIV100_SHIFT];
      end
    end
    res_data.valid_res           = s4_ok;
    res_data.inject_delay_first  = s4_ok ? delay[0] : '0;
    res_data.inject_delay_second = s4_ok ? delay[1] : '0;
    res_data.spark_delay_first   = s4_ok ? delay[2] : '0;
    res_data.spark_delay_second  = s4_ok ? delay[3] : '0;
    res_data.pulse_width_out     = s4_ok ? s4_pw : '0;
  end

  assign res_wr = s_vld[3];

endmodule

`default_nettype wire

// ===== rtl/core/atdps_outq.sv =====
// Result queue: RAM-backed FIFO with a show-ahead head register.
// Depends on atdps_pkg and atdps_ram.
`timescale 1ns / 1ps
`default_nettype none

module atdps_outq #(
  parameter int unsigned DEPTH = atdps_pkg::OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  atdps_pkg::res_t                wr_data,
  output logic                           empty,
  input  logic                           pop,
  output atdps_pkg::res_t                head,
  output logic [$clog2(DEPTH+1)-1:0]     level
);
  import atdps_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] ram_cnt;
  logic          head_vld;
  logic          pop_acc;
  logic          rd_en;

  assign pop_acc = pop && head_vld;
  // refill the head when it is free or leaving
  assign rd_en   = (ram_cnt != '0) && (!head_vld || pop_acc);
  assign empty   = !head_vld;
  assign level   = ram_cnt + CW'(head_vld);

  atdps_ram #(
    .WIDTH ($bits(res_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ptr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr),
    .rd_data (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      ram_cnt  <= '0;
      head_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      ram_cnt  <= ram_cnt + CW'(wr_en) - CW'(rd_en);
      head_vld <= rd_en || (head_vld && !pop_acc);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/angle_to_delay_pair_scheduler_top.sv =====
// Top level of the crank-angle to delay scheduler (wasted spark, paired injection).
// Depends on atdps_pkg, atdps_front, atdps_back, atdps_outq.
//
// Usage:
//   Requests enter like a queue write: a transaction takes place at a clock edge
//   with push high and full low. Results leave like a queue read: while empty is
//   low the oldest result is on res, and pop with empty low takes it.
//   Registers are written through cfg_we/cfg_addr/cfg_data, one per clock with
//   no wait: index 0 is the tooth count, index 1 the end-of-injection angle.
//   Change them only while no request is in flight.
// Timing:
//   One request per clock sustained while the result queue keeps draining. A
//   request passes the issue stage, the one-bit-per-stage divider pipeline,
//   then the angle, distance, multiply, reciprocal and queue stages.
// Reset (rst, synchronous) empties every queue and loads the register defaults.
// Stall: results wait in a 64-entry result queue; when it and the pipeline are
// committed the back end stops issuing, the 4-entry job queue fills and full
// rises. Nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module angle_to_delay_pair_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = atdps_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH   = atdps_pkg::OUT_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  atdps_pkg::req_t                  req,
  output logic                             empty,
  input  logic                             pop,
  output atdps_pkg::res_t                  res,
  input  logic                             cfg_we,
  input  logic [atdps_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [atdps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import atdps_pkg::*;

  localparam int LVL_W = $clog2(OUT_DEPTH + 1);

  logic             job_valid;
  job_t             job;
  logic             job_pop;
  logic             back_wr;
  res_t             back_res;
  logic [LVL_W-1:0] out_level;

  atdps_front #(.DEPTH (QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  atdps_back #(.OUT_DEPTH (OUT_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .out_level (out_level),
    .res_wr    (back_wr),
    .res_data  (back_res)
  );

  atdps_outq #(.DEPTH (OUT_DEPTH)) u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (back_wr),
    .wr_data (back_res),
    .empty   (empty),
    .pop     (pop),
    .head    (res),
    .level   (out_level)
  );

`ifndef SYNTH
  // the credit scheme must never let the result queue overflow
  a_outq_room: assert property (@(posedge clk) disable iff (rst)
    back_wr |-> (out_level < LVL_W'(OUT_DEPTH)))
    else $error("result queue written while full");

  // back end only takes jobs that the front end offers
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> job_valid)
    else $error("job taken from an empty job queue");

  // after reset both sides start empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");
`endif

endmodule

`default_nettype wire
